### rtl/core/rsps_pkg.sv
package rsps_pkg;

  // tree geometry
  localparam int unsigned Leaves = 1024;
  localparam int unsigned LeafW  = $clog2(Leaves);
  localparam int unsigned NodeW  = LeafW + 1;
  localparam int unsigned Nodes  = 2 * Leaves;
  // bound registers of a query walk; they can reach Nodes itself
  localparam int unsigned BoundW = NodeW + 1;

  // payload widths
  localparam int unsigned DataW  = 64;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CountW = 11;

  // operation codes
  localparam logic OpSet   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef logic [DataW-1:0] data_t;

endpackage

### rtl/core/range_sum_point_set_tree_core.sv
// set: busy while it walks from leaf to root, no result; a dropped set never raises busy
// query: busy through S_Q_LO and S_Q_HI per level, then a last S_Q_LO; range_sum_valid_o
//   strobes for one cycle, the first with busy low; the receiver cannot stall it
// pace set by the one read port: sibling read and write back per level on a set, up to two
//   reads per level on a query; the next item may start as soon as busy is low
// reset: asynchronous, active low, then a clearing pass zeroes all 2048 nodes with busy high
module range_sum_point_set_tree_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [rsps_pkg::IdxW-1:0]   position_i,
  input  logic signed [rsps_pkg::DataW-1:0] value_i,
  input  logic [rsps_pkg::IdxW-1:0]   first_index_i,
  input  logic [rsps_pkg::IdxW-1:0]   last_index_i,
  // result strobe
  output logic                        range_sum_valid_o,
  output logic signed [rsps_pkg::DataW-1:0] range_sum_o,
  // active count register write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rsps_pkg::CountW-1:0] cfg_data_i
);

  localparam int unsigned NodeW  = rsps_pkg::NodeW;
  localparam int unsigned BoundW = rsps_pkg::BoundW;
  localparam int unsigned CountW = rsps_pkg::CountW;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SET_WR  = 6'b000100,
    S_SET_SUM = 6'b001000,
    S_Q_LO    = 6'b010000,
    S_Q_HI    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [NodeW-1:0]  clr_q, clr_d;
  logic [NodeW-1:0]  idx_q, idx_d;
  rsps_pkg::data_t   cur_q, cur_d;
  logic [BoundW-1:0] lo_q, lo_d;
  logic [BoundW-1:0] hi_q, hi_d;
  rsps_pkg::data_t   acc_q, acc_d;
  logic              res_vld_q, res_vld_d;
  rsps_pkg::data_t   res_q, res_d;

  // node memory, one write and one registered read per cycle
  rsps_pkg::data_t   mem [rsps_pkg::Nodes];
  logic              mem_we, mem_re;
  logic [NodeW-1:0]  mem_waddr, mem_raddr;
  rsps_pkg::data_t   mem_wdata;
  rsps_pkg::data_t   rdata_q;
  logic              rd_vld_q;

  logic [CountW-1:0] count_eff;
  logic [CountW-1:0] last_max;
  logic [CountW-1:0] last_ext;
  logic [CountW-1:0] last_clip;
  rsps_pkg::data_t   acc_sum;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;

  // a count of zero acts as one, anything above the leaf count as the leaf count
  always_comb begin
    if (count_q == '0) begin
      count_eff = CountW'(1);
    end else if (count_q > CountW'(rsps_pkg::Leaves)) begin
      count_eff = CountW'(rsps_pkg::Leaves);
    end else begin
      count_eff = count_q;
    end
  end

  assign last_max  = count_eff - CountW'(1);
  assign last_ext  = CountW'(last_index_i);
  assign last_clip = (last_ext > last_max) ? last_max : last_ext;

  // fold in the read issued last cycle
  assign acc_sum = acc_q + (rd_vld_q ? rdata_q : '0);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = cur_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q ^ NodeW'(1);

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + NodeW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (operation_i == rsps_pkg::OpSet) begin
            // a set beyond the active count is dropped
            if (CountW'(position_i) < count_eff) begin
              idx_d   = NodeW'(rsps_pkg::Leaves) + NodeW'(position_i);
              cur_d   = value_i;
              state_d = S_SET_WR;
            end
          end else begin
            // an empty range leaves lo >= hi and exits at once with zero
            lo_d    = BoundW'(rsps_pkg::Leaves) + BoundW'(first_index_i);
            hi_d    = BoundW'(rsps_pkg::Leaves) + BoundW'(last_clip) + BoundW'(1);
            acc_d   = '0;
            state_d = S_Q_LO;
          end
        end
      end

      // write the current node, fetch its sibling unless at the root
      S_SET_WR: begin
        mem_we = 1'b1;
        if (idx_q == NodeW'(1)) begin
          state_d = S_IDLE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_SET_SUM;
        end
      end

      S_SET_SUM: begin
        cur_d   = cur_q + rdata_q;
        idx_d   = idx_q >> 1;
        state_d = S_SET_WR;
      end

      // left bound of the level
      S_Q_LO: begin
        acc_d = acc_sum;
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = lo_q[NodeW-1:0];
            lo_d      = lo_q + BoundW'(1);
          end
          state_d = S_Q_HI;
        end else begin
          res_vld_d = 1'b1;
          res_d     = acc_sum;
          state_d   = S_IDLE;
        end
      end

      // right bound of the level, then climb
      S_Q_HI: begin
        acc_d = acc_sum;
        if (hi_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = {hi_q[NodeW-1:1], 1'b0};
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_q >> 1;
        state_d = S_Q_LO;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      count_q   <= CountW'(rsps_pkg::Leaves);
      res_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      res_vld_q <= res_vld_d;
      rd_vld_q  <= mem_re;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // walk registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign range_sum_valid_o = res_vld_q;
  assign range_sum_o       = res_q;

`ifndef SYNTHESIS
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_sum_valid_o |-> $past(state_q == S_Q_LO))
    else $error("result strobe without a finished query walk");

  a_query_exit_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_LO && !(lo_q < hi_q)) |=> range_sum_valid_o)
    else $error("finished query walk gave no result");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_LO || state_q == S_Q_HI) |-> !mem_we)
    else $error("node memory written during a query");

  a_set_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SET_WR) |-> (idx_q != '0))
    else $error("set walk climbed past the root");
`endif

endmodule

### sim/testbench.sv
module testbench;

  localparam int unsigned Leaves = rsps_pkg::Leaves;
  localparam int unsigned LeafW  = rsps_pkg::LeafW;
  localparam int unsigned IdxW   = rsps_pkg::IdxW;
  localparam int unsigned CountW = rsps_pkg::CountW;
  localparam int unsigned DataW  = rsps_pkg::DataW;
  localparam logic OpSet   = rsps_pkg::OpSet;
  localparam logic OpQuery = rsps_pkg::OpQuery;

  typedef rsps_pkg::data_t data_t;

  // cycles the block may still work on a set once the last sum is back
  localparam int unsigned SettleCycles = 2 * LeafW + 8;
  // items per phase of the random part
  localparam int unsigned PhaseItems = 85;

  typedef enum logic {
    BeatCmd,
    BeatCfg
  } beat_kind_e;

  typedef struct {
    beat_kind_e            kind;
    logic                  op;
    logic [IdxW-1:0]       pos;
    data_t                 value;
    logic [IdxW-1:0]       first;
    logic [IdxW-1:0]       last;
    logic [CountW-1:0]     count;
  } tree_beat_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                     start         = 1'b0;
  logic                     operation_i   = OpSet;
  logic [IdxW-1:0]          position_i    = '0;
  logic signed [DataW-1:0]  value_i       = '0;
  logic [IdxW-1:0]          first_index_i = '0;
  logic [IdxW-1:0]          last_index_i  = '0;
  logic                     cfg_valid_i   = 1'b0;
  logic [CountW-1:0]        cfg_data_i    = '0;

  // block outputs
  logic                     busy;
  logic                     range_sum_valid_o;
  logic signed [DataW-1:0]  range_sum_o;
  logic                     cfg_ready_o;

  range_sum_point_set_tree_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .position_i        (position_i),
    .value_i           (value_i),
    .first_index_i     (first_index_i),
    .last_index_i      (last_index_i),
    .range_sum_valid_o (range_sum_valid_o),
    .range_sum_o       (range_sum_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  // beats waiting to be driven, sums waiting to come back
  tree_beat_t        tree_ops [$];
  data_t             expected_sums [$];
  int unsigned       mismatch_count = 0;

  // shadow copy of the elements and the active count register
  data_t             elem_shadow [Leaves];
  logic [CountW-1:0] shadow_count;

  // a count of zero behaves as one, anything above the leaf count as full
  function automatic int unsigned clamp_count(logic [CountW-1:0] c);
    if (c == 0) return 1;
    if (c > Leaves) return Leaves;
    return 32'(c);
  endfunction

  // applies one accepted command to the shadow; a query queues its sum
  task automatic predict_tree_op(tree_beat_t b);
    int unsigned cnt;
    int unsigned hi;
    int unsigned k;
    data_t       acc;
    cnt = clamp_count(shadow_count);
    if (b.op == OpSet) begin
      // sets past the active count are dropped
      if (32'(b.pos) < cnt) elem_shadow[b.pos] = b.value;
    end else begin
      // last index clipped to the active range, empty range sums to zero
      hi  = 32'(b.last);
      if (hi > cnt - 1) hi = cnt - 1;
      acc = '0;
      if (32'(b.first) <= hi) begin
        for (k = 32'(b.first); k <= hi; k++) acc += elem_shadow[k];
      end
      expected_sums.push_back(acc);
    end
  endtask

  task automatic add_op(logic op, int unsigned pos, data_t v, int unsigned f, int unsigned l);
    tree_beat_t b;
    b.kind  = BeatCmd;
    b.op    = op;
    b.pos   = pos[IdxW-1:0];
    b.value = v;
    b.first = f[IdxW-1:0];
    b.last  = l[IdxW-1:0];
    b.count = '0;
    tree_ops.push_back(b);
  endtask

  task automatic add_count_write(int unsigned c);
    tree_beat_t b;
    b.kind  = BeatCfg;
    b.op    = OpSet;
    b.pos   = '0;
    b.value = '0;
    b.first = '0;
    b.last  = '0;
    b.count = c[CountW-1:0];
    tree_ops.push_back(b);
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(DataW-1){1'b1}}};
      1:       return {1'b1, {(DataW-1){1'b0}}};
      2, 3:    return data_t'(signed'(64'($urandom_range(0, 40))) - 20);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one random command shaped around the active count of its phase
  task automatic add_rand_op(int unsigned cnt);
    int unsigned pos;
    int unsigned f;
    int unsigned l;
    logic        op;
    op  = $urandom_range(0, 1) ? OpQuery : OpSet;
    pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, cnt - 1) : $urandom_range(0, Leaves - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        f = $urandom_range(0, cnt - 1);
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(f, Leaves - 1)
                                        : $urandom_range(f, cnt - 1);
      end
      5, 6: begin
        f = $urandom_range(0, Leaves - 1);
        l = $urandom_range(0, Leaves - 1);
      end
      7: begin
        f = $urandom_range(0, Leaves - 1);
        l = f;
      end
      default: begin
        // first above last
        f = $urandom_range(1, Leaves - 1);
        l = $urandom_range(0, f - 1);
      end
    endcase
    add_op(op, pos, rand_value(), f, l);
  endtask

  // driver: bursts of commands with random gaps, count writes only once idle
  int unsigned gap_left   = 0;
  int unsigned burst_left = 4;
  int unsigned idle_run   = 0;
  tree_beat_t  cur_op;

  always @(posedge clk_i) begin
    logic nxt_start;
    logic nxt_cfg_valid;
    nxt_start     = start;
    nxt_cfg_valid = cfg_valid_i;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_tree_op(cur_op);
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_count  = cfg_data_i;
        nxt_cfg_valid = 1'b0;
      end
      // quiet time since the block last had anything to do
      if (busy || start || cfg_valid_i || expected_sums.size() != 0) idle_run = 0;
      else idle_run++;
      if (!nxt_start && !nxt_cfg_valid && tree_ops.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (tree_ops[0].kind == BeatCmd) begin
          cur_op = tree_ops.pop_front();
          operation_i   <= cur_op.op;
          position_i    <= cur_op.pos;
          value_i       <= cur_op.value;
          first_index_i <= cur_op.first;
          last_index_i  <= cur_op.last;
          nxt_start     = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else if (idle_run >= SettleCycles) begin
          // count write waits for every sum and for any set still in flight
          cur_op = tree_ops.pop_front();
          cfg_data_i    <= cur_op.count;
          nxt_cfg_valid = 1'b1;
        end
      end
    end
    start       <= nxt_start;
    cfg_valid_i <= nxt_cfg_valid;
  end

  // monitor: every strobe checked against the oldest predicted sum
  always @(posedge clk_i) begin
    data_t exp_sum;
    if (rst_ni && range_sum_valid_o) begin
      if (expected_sums.size() == 0) begin
        $error("range_sum: no result pending, got %0d", range_sum_o);
        mismatch_count++;
      end else begin
        exp_sum = expected_sums.pop_front();
        if (range_sum_o !== exp_sum) begin
          $error("range_sum: expected %0d, got %0d", $signed(exp_sum), range_sum_o);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus plan and end of run
  initial begin
    int unsigned phase_counts [10];
    int unsigned i;
    int unsigned j;
    data_t max_v;
    data_t min_v;
    phase_counts = '{1, 2, 7, 64, 1024, 0, 1000, 2047, 512, 1025};
    max_v = {1'b0, {(DataW-1){1'b1}}};
    min_v = {1'b1, {(DataW-1){1'b0}}};
    for (i = 0; i < Leaves; i++) elem_shadow[i] = '0;
    shadow_count = 11'd1024;

    // directed: reset count, cleared store, extremes and wrap
    add_op(OpQuery, 0, '0, 0, Leaves - 1);
    add_op(OpSet, 0, max_v, 0, 0);
    add_op(OpSet, Leaves - 1, min_v, 0, 0);
    add_op(OpSet, 512, '1, 0, 0);
    add_op(OpSet, 1, data_t'(1), 0, 0);
    add_op(OpQuery, 0, '0, 0, Leaves - 1);
    add_op(OpQuery, 0, '0, 0, 1);
    add_op(OpQuery, 0, '0, Leaves - 1, Leaves - 1);
    add_op(OpQuery, 0, '0, 5, 3);
    add_op(OpQuery, 0, '0, Leaves - 1, 0);
    // reduced count: sets beyond ignored, last index clipped, empty ranges
    add_count_write(16);
    add_op(OpSet, 20, data_t'(77), 0, 0);
    add_op(OpSet, 15, data_t'(5), 0, 0);
    add_op(OpQuery, 0, '0, 0, Leaves - 1);
    add_op(OpQuery, 0, '0, 16, Leaves - 1);
    add_op(OpQuery, 0, '0, 20, 30);
    // zero count behaves as one
    add_count_write(0);
    add_op(OpSet, 1, data_t'(9), 0, 0);
    add_op(OpQuery, 0, '0, 0, Leaves - 1);
    add_op(OpQuery, 0, '0, 1, 1);
    // oversized count behaves as full, hidden elements come back
    add_count_write(2047);
    add_op(OpQuery, 0, '0, 0, Leaves - 1);
    add_op(OpQuery, 0, '0, 20, 20);

    // random phases, each under its own active count
    for (i = 0; i < 10; i++) begin
      add_count_write(phase_counts[i]);
      for (j = 0; j < PhaseItems; j++) add_rand_op(clamp_count(CountW'(phase_counts[i])));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (tree_ops.size() != 0 || start || cfg_valid_i || busy || expected_sums.size() != 0);
    repeat (SettleCycles + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("range_sum_point_set_tree_core test passed");
    end else begin
      $display("range_sum_point_set_tree_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("range_sum_point_set_tree_core test failed");
    $finish;
  end

endmodule

### files.f
rtl/core/rsps_pkg.sv
rtl/core/range_sum_point_set_tree_core.sv
sim/testbench.sv
